[design/qpk_pkg.sv]
// qpk_pkg: shared types, codes, reset values and the quadrature decode table
// for the quadrature position knob. No dependencies.

package qpk_pkg;

    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 8;

    localparam logic [CFG_IDX_W-1:0] CFG_POS_MIN = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_POS_MAX = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_A = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_B = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_C = 3'd4;

    localparam logic [7:0] POS_MIN_RST = 8'd0;
    localparam logic [7:0] POS_MAX_RST = 8'd255;
    localparam logic [7:0] STEP_A_RST = 8'd1;
    localparam logic [7:0] STEP_B_RST = 8'd2;
    localparam logic [7:0] STEP_C_RST = 8'd5;
    localparam logic [7:0] POS_INIT = 8'd155;

    typedef enum logic [1:0] {
        MODE_SAMPLE = 2'd0,
        MODE_SET_POS = 2'd1,
        MODE_CLEAR = 2'd2,
        MODE_CYCLE = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        EV_NONE = 2'd0,
        EV_UP = 2'd1,
        EV_DOWN = 2'd2,
        EV_ILLEGAL = 2'd3
    } step_event_t;

    // indexed by previous pin pair * 4 + current pin pair
    localparam step_event_t GRAY_MOVE [16] = '{
        EV_NONE, EV_UP, EV_DOWN, EV_ILLEGAL,
        EV_DOWN, EV_NONE, EV_ILLEGAL, EV_UP,
        EV_UP, EV_ILLEGAL, EV_NONE, EV_DOWN,
        EV_ILLEGAL, EV_DOWN, EV_UP, EV_NONE
    };

    typedef struct packed {
        logic [7:0] pos_min;
        logic [7:0] pos_max;
        logic [7:0] step_a;
        logic [7:0] step_b;
        logic [7:0] step_c;
    } cfg_t;

    typedef struct packed {
        mode_t              mode;
        logic               pin_a;
        logic               pin_b;
        logic               button_level;
        logic signed [15:0] new_position;
    } item_t;

    typedef struct packed {
        logic [7:0]  position;
        logic [31:0] press_count;
        logic        button_down;
        logic [7:0]  step_size;
        step_event_t step_event;
    } result_t;

endpackage

[design/quadrature_position_knob.sv]
// quadrature_position_knob: top level with the request register, the knob
// core and the result register. Depends on qpk_pkg, qpk_cfg_regs, qpk_core.
//
// Usage: each request on the s_ channel is either a sample of the encoder
// pins and the active-low button (mode 0) or a command: set position,
// clear press count, cycle step size. Every request yields exactly one
// result on the m_ channel with the position, press count, button state,
// selected step size and the decoded step event.
// Timing: a request accepted into the request register is evaluated
// combinationally against the knob state and lands in the result register
// when it advances, from where its result is offered on the m_ channel.
// Throughput: one request per cycle while m_ready does not stall the result; the state update is one add and clamp.
// A stall on m_ready holds the result register; the request register still
// takes one more request, after which s_ready drops until the result moves.
// Reset (aresetn low, synchronous) empties both registers, sets position to
// 155, step index, presses, pins and button to zero and the configuration
// to its defaults. The user must write configuration through cfg_wr_en only
// while no request is in flight; the block itself does not enforce this.

module quadrature_position_knob
    import qpk_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,

    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,

    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [1:0]            s_mode,
    input  logic                  s_pin_a,
    input  logic                  s_pin_b,
    input  logic                  s_button_level,
    input  logic signed [15:0]    s_new_position,

    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [7:0]            m_position,
    output logic [31:0]           m_press_count,
    output logic                  m_button_down,
    output logic [7:0]            m_step_size,
    output logic [1:0]            m_step_event
);

    cfg_t    cfg;
    item_t   item_reg;
    logic    item_valid_reg;
    result_t result;
    result_t result_reg;
    logic    result_valid_reg;
    logic    advance;

    qpk_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    qpk_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .advance (advance),
        .item    (item_reg),
        .cfg     (cfg),
        .result  (result)
    );

    assign advance = item_valid_reg && (!result_valid_reg || m_ready);
    assign s_ready = !item_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            item_valid_reg <= 1'b0;
            result_valid_reg <= 1'b0;
        end else begin
            if (s_ready) begin
                item_valid_reg <= s_valid;
            end
            if (!result_valid_reg || m_ready) begin
                result_valid_reg <= item_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            item_reg.mode <= mode_t'(s_mode);
            item_reg.pin_a <= s_pin_a;
            item_reg.pin_b <= s_pin_b;
            item_reg.button_level <= s_button_level;
            item_reg.new_position <= s_new_position;
        end
        if (advance) begin
            result_reg <= result;
        end
    end

    assign m_valid = result_valid_reg;
    assign m_position = result_reg.position;
    assign m_press_count = result_reg.press_count;
    assign m_button_down = result_reg.button_down;
    assign m_step_size = result_reg.step_size;
    assign m_step_event = result_reg.step_event;

endmodule

[design/qpk_cfg_regs.sv]
// qpk_cfg_regs: configuration register file (clamp range, three step sizes).
// Depends on qpk_pkg.

module qpk_cfg_regs
    import qpk_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    output cfg_t                  cfg
);

    cfg_t cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.pos_min <= POS_MIN_RST;
            cfg_reg.pos_max <= POS_MAX_RST;
            cfg_reg.step_a <= STEP_A_RST;
            cfg_reg.step_b <= STEP_B_RST;
            cfg_reg.step_c <= STEP_C_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_POS_MIN: cfg_reg.pos_min <= cfg_wdata;
                CFG_POS_MAX: cfg_reg.pos_max <= cfg_wdata;
                CFG_STEP_A: cfg_reg.step_a <= cfg_wdata;
                CFG_STEP_B: cfg_reg.step_b <= cfg_wdata;
                CFG_STEP_C: cfg_reg.step_c <= cfg_wdata;
                default: ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

[design/qpk_core.sv]
// qpk_core: knob state (position, pins, button, presses, step index) and the
// combinational decode, step and clamp logic. Depends on qpk_pkg.

module qpk_core
    import qpk_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    advance,
    input  item_t   item,
    input  cfg_t    cfg,
    output result_t result
);

    logic [7:0]  pos_reg, pos_next;
    logic [1:0]  prev_pins_reg, prev_pins_next;
    logic        held_reg, held_next;
    logic [31:0] presses_reg, presses_next;
    logic [1:0]  step_index_reg, step_index_next;

    logic [1:0]   pins;
    logic         press;
    logic [7:0]   step;
    step_event_t  event_code;
    step_event_t  event_out;
    logic signed [16:0] pos_ext;
    logic signed [16:0] step_ext;

    function automatic logic [7:0] clamp_pos(input logic signed [16:0] v,
                                             input logic [7:0] lo,
                                             input logic [7:0] hi);
        logic signed [16:0] r;
        r = v;
        if (r > $signed({9'd0, hi})) begin
            r = $signed({9'd0, hi});
        end
        if (r < $signed({9'd0, lo})) begin
            r = $signed({9'd0, lo});
        end
        return r[7:0];
    endfunction

    function automatic logic [1:0] next_index(input logic [1:0] idx);
        return (idx >= 2'd2) ? 2'd0 : idx + 2'd1;
    endfunction

    function automatic logic [7:0] pick_step(input logic [1:0] idx, input cfg_t c);
        priority if (idx == 2'd0) begin
            return c.step_a;
        end else if (idx == 2'd1) begin
            return c.step_b;
        end else begin
            return c.step_c;
        end
    endfunction

    assign pins = {item.pin_a, item.pin_b};
    assign press = !item.button_level && !held_reg;
    assign event_code = GRAY_MOVE[{prev_pins_reg, pins}];
    assign pos_ext = $signed({9'd0, pos_reg});

    always_comb begin
        pos_next = pos_reg;
        prev_pins_next = prev_pins_reg;
        held_next = held_reg;
        presses_next = presses_reg;
        step_index_next = step_index_reg;
        event_out = EV_NONE;
        unique case (item.mode)
            MODE_SAMPLE: begin
                held_next = !item.button_level;
                if (press) begin
                    presses_next = presses_reg + 32'd1;
                    step_index_next = next_index(step_index_reg);
                end
                event_out = event_code;
                prev_pins_next = pins;
            end
            MODE_SET_POS: begin
                pos_next = clamp_pos({item.new_position[15], item.new_position},
                                     cfg.pos_min, cfg.pos_max);
            end
            MODE_CLEAR: begin
                presses_next = 32'd0;
            end
            MODE_CYCLE: begin
                step_index_next = next_index(step_index_reg);
            end
            default: ;
        endcase
        step = pick_step(step_index_next, cfg);
        step_ext = $signed({9'd0, step});
        if (item.mode == MODE_SAMPLE) begin
            unique case (event_code)
                EV_UP: pos_next = clamp_pos(pos_ext + step_ext, cfg.pos_min, cfg.pos_max);
                EV_DOWN: pos_next = clamp_pos(pos_ext - step_ext, cfg.pos_min, cfg.pos_max);
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg <= POS_INIT;
            prev_pins_reg <= 2'd0;
            held_reg <= 1'b0;
            presses_reg <= 32'd0;
            step_index_reg <= 2'd0;
        end else if (advance) begin
            pos_reg <= pos_next;
            prev_pins_reg <= prev_pins_next;
            held_reg <= held_next;
            presses_reg <= presses_next;
            step_index_reg <= step_index_next;
        end
    end

    assign result.position = pos_next;
    assign result.press_count = presses_next;
    assign result.button_down = held_next;
    assign result.step_size = step;
    assign result.step_event = event_out;

    a_index_range: assert property (@(posedge aclk) disable iff (!aresetn)
        step_index_reg != 2'd3)
        else $error("step index left its range");

    a_clear_count: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && item.mode == MODE_CLEAR |=> presses_reg == 32'd0)
        else $error("press count not cleared");

    a_cmd_keeps_pins: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && item.mode != MODE_SAMPLE |=> $stable(prev_pins_reg) && $stable(held_reg))
        else $error("command changed pin or button state");

    a_set_keeps_index: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && (item.mode == MODE_SET_POS || item.mode == MODE_CLEAR)
        |=> $stable(step_index_reg))
        else $error("step index moved on a set or clear");

    a_press_counts: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && item.mode == MODE_SAMPLE && press |=> presses_reg == $past(presses_reg) + 32'd1)
        else $error("button press not counted");

endmodule
